// ----- rtl/julian_day_conversion_defines.svh -----
// Assertion macros for the Julian day conversion block.
`ifndef JULIAN_DAY_CONVERSION_DEFINES_SVH
`define JULIAN_DAY_CONVERSION_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define JDC_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("jdc check failed");

// Implication after a fixed number of cycles, disabled during reset.
`define JDC_ASSERT_DELAY(label, clk, rst, ante, n, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##n (cons)) \
    else $error("jdc latency check failed");

`endif

// ----- rtl/jdc_pkg.sv -----
// Types, constants and reciprocal divider settings for the Julian day conversion block.
package jdc_pkg;

  localparam logic ReqDateToJdn = 1'b0;
  localparam logic ReqJdnToDate = 1'b1;

  localparam int YearMax        = 9999;
  localparam int JdnYearBase    = 4800;
  localparam int JdnCentBase    = 4900;
  localparam int QuadYearDays   = 1461;
  localparam int JdnEpoch       = 32075;
  localparam int JdnShift       = 68569;
  localparam int CenturyDays    = 146097;
  localparam int YearScale      = 4000;
  localparam int YearDiv        = 1461001;
  localparam int MonthScale     = 80;
  localparam int MonthDiv       = 2447;
  localparam int DayBias        = 31;
  localparam int YearLo         = JdnCentBase;
  localparam int YearHi         = YearMax + JdnCentBase;

  // Reciprocal multipliers: floor(n * M >> S) == n / D for n below 2**N.
  localparam int     Div100N  = 15;
  localparam int     Div100S  = Div100N + $clog2(100);
  localparam int     Div100PW = 2 * Div100N + 1;
  localparam longint Div100M  = ((longint'(1) << Div100S) + 100 - 1) / 100;

  localparam int     DivCentN  = 26;
  localparam int     DivCentS  = DivCentN + $clog2(CenturyDays);
  localparam int     DivCentPW = 2 * DivCentN + 1;
  localparam longint DivCentM  =
    ((longint'(1) << DivCentS) + CenturyDays - 1) / CenturyDays;

  localparam int     DivYearN  = 28;
  localparam int     DivYearS  = DivYearN + $clog2(YearDiv);
  localparam int     DivYearPW = 2 * DivYearN + 1;
  localparam longint DivYearM  = ((longint'(1) << DivYearS) + YearDiv - 1) / YearDiv;

  localparam int     DivMonN  = 16;
  localparam int     DivMonS  = DivMonN + $clog2(MonthDiv);
  localparam int     DivMonPW = 2 * DivMonN + 1;
  localparam longint DivMonM  = ((longint'(1) << DivMonS) + MonthDiv - 1) / MonthDiv;

  localparam int RevLatency = 9;
  localparam int FwdStages  = 3;
  localparam int Latency    = RevLatency + 2;

  // (367 * k) / 12 indexed by month, k = month - 2 + 12 for January and February
  localparam logic [8:0] MonthOffset [0:15] = '{
    9'd305, 9'd336, 9'd367, 9'd30, 9'd61, 9'd91, 9'd122, 9'd152,
    9'd183, 9'd214, 9'd244, 9'd275, 9'd305, 9'd336, 9'd367, 9'd397
  };

  // (2447 * t) / 80 indexed by t
  localparam logic [8:0] DayOffset [0:15] = '{
    9'd0, 9'd30, 9'd61, 9'd91, 9'd122, 9'd152, 9'd183, 9'd214,
    9'd244, 9'd275, 9'd305, 9'd336, 9'd367, 9'd397, 9'd428, 9'd458
  };

  typedef struct packed {
    logic        req_type;
    logic [13:0] year_in;
    logic [3:0]  month_in;
    logic [4:0]  day_in;
    logic [22:0] julian_in;
  } jdc_req_t;

  typedef struct packed {
    logic [22:0] julian_out;
    logic [13:0] year_out;
    logic [3:0]  month_out;
    logic [4:0]  day_out;
    logic [26:0] packed_date;
    logic        date_valid;
    logic        range_error;
  } jdc_res_t;

  typedef struct packed {
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic        range_error;
  } jdc_date_t;

endpackage

// ----- rtl/jdc_jdn_to_date.sv -----
// Pipelined Julian day number to Gregorian date converter.
module jdc_jdn_to_date (
  input  logic               clk,
  input  logic [22:0]        julian,
  output jdc_pkg::jdc_date_t date
);
  import jdc_pkg::*;

  logic [23:0]          r1;
  logic [23:0]          r2;
  logic [DivCentPW-1:0] pc2;
  logic [23:0]          r3;
  logic [7:0]           c3;
  logic [25:0]          cm3;
  logic [15:0]          r4;
  logic [7:0]           c4;
  logic [27:0]          n5;
  logic [15:0]          r5;
  logic [7:0]           c5;
  logic [DivYearPW-1:0] pq6;
  logic [15:0]          r6;
  logic [7:0]           c6;
  logic [8:0]           r7;
  logic [6:0]           q7;
  logic [7:0]           c7;
  logic [DivMonPW-1:0]  pt8;
  logic [8:0]           r8;
  logic [6:0]           q8;
  logic [7:0]           c8;

  logic [7:0]  c_w;
  logic [25:0] cm_p3;
  logic [23:0] r_sub;
  logic [6:0]  q_w;
  logic [17:0] qd_w;
  logic [17:0] r7_w;
  logic [3:0]  t_w;
  logic        u_w;
  logic [8:0]  d_w;
  logic [14:0] yr_w;
  jdc_date_t   date_next;

  always_comb begin
    c_w   = pc2[DivCentS +: 8];
    cm_p3 = cm3 + 26'd3;
    r_sub = r3 - 24'(cm_p3[25:2]);
    q_w   = pq6[DivYearS +: 7];
    qd_w  = 18'(q_w) * 18'(QuadYearDays);
    r7_w  = 18'(r6) + 18'(DayBias) - 18'(qd_w[17:2]);
    t_w   = pt8[DivMonS +: 4];
    u_w   = (t_w >= 4'd11);
    d_w   = r8 - DayOffset[t_w];
    yr_w  = 15'(c8) * 15'd100 + 15'(q8) + 15'(u_w);
    date_next.day         = d_w[4:0];
    date_next.month       = t_w + 4'd2 - (u_w ? 4'd12 : 4'd0);
    date_next.year        = 14'(yr_w - 15'(YearLo));
    date_next.range_error = (yr_w < 15'(YearLo)) || (yr_w > 15'(YearHi));
  end

  always_ff @(posedge clk) begin
    r1  <= 24'(julian) + 24'(JdnShift);
    pc2 <= DivCentPW'({r1, 2'b00}) * DivCentPW'(DivCentM);
    r2  <= r1;
    c3  <= c_w;
    cm3 <= 26'(c_w) * 26'(CenturyDays);
    r3  <= r2;
    r4  <= r_sub[15:0];
    c4  <= c3;
    n5  <= (28'(r4) + 28'd1) * 28'(YearScale);
    r5  <= r4;
    c5  <= c4;
    pq6 <= DivYearPW'(n5) * DivYearPW'(DivYearM);
    r6  <= r5;
    c6  <= c5;
    r7  <= r7_w[8:0];
    q7  <= q_w;
    c7  <= c6;
    pt8 <= DivMonPW'(r7) * DivMonPW'(MonthScale * DivMonM);
    r8  <= r7;
    q8  <= q7;
    c8  <= c7;
    date <= date_next;
  end

endmodule

// ----- rtl/julian_day_conversion.sv -----
// Top level of the Julian day conversion block: date to Julian day and back.
//
//   channel  | ports                      | transfer
//   ---------+----------------------------+--------------------------------
//   request  | start, busy, request       | edge with start high, busy low
//   result   | done, result               | edge that ends the done cycle
//
// Takes one request every clock while busy is low; the result depth is set by the
// reverse chain with its three reciprocal multiplies, plus the select and result stages.
// Synchronous reset clears the valid bits; busy is high while rst is high.
// The result side has no backpressure, so the pipeline never stalls.
module julian_day_conversion (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  jdc_pkg::jdc_req_t request,
  output logic              done,
  output jdc_pkg::jdc_res_t result
);
  import jdc_pkg::*;

  localparam int FwdPad = RevLatency - FwdStages + 1;

  typedef struct packed {
    jdc_date_t   date;
    logic [22:0] jdn;
  } fwd_t;

  typedef struct packed {
    logic        req_type;
    logic [22:0] julian;
  } info_t;

  logic                vld [0:Latency-1];
  info_t               info [0:RevLatency-1];
  fwd_t                pad [0:FwdPad-1];

  logic [13:0]         f1_y;
  logic [3:0]          f1_m;
  logic [4:0]          f1_d;
  logic [14:0]         f1_k1;
  logic [14:0]         f1_k3;
  logic                f1_err;
  logic [24:0]         f2_p1;
  logic [Div100PW-1:0] f2_p3;
  logic [8:0]          f2_t2;
  logic [13:0]         f2_y;
  logic [3:0]          f2_m;
  logic [4:0]          f2_d;
  logic                f2_err;

  jdc_date_t           rev_date;
  jdc_date_t           m10_date;
  logic [22:0]         m10_j;
  logic [Div100PW-1:0] m10_yp;
  jdc_res_t            res;

  logic [14:0] year_ext;
  logic [7:0]  q100;
  logic [9:0]  t3x;
  logic [24:0] jsum;
  fwd_t        f3_next;
  info_t       info_last;
  fwd_t        pad_last;
  jdc_date_t   sel_date;
  logic [22:0] sel_j;
  logic [7:0]  yq;
  logic [13:0] hund;
  logic        leap;
  logic [4:0]  mlen;
  logic        ok;
  jdc_res_t    res_next;

  function automatic logic [4:0] month_days(input logic [3:0] month, input logic is_leap);
    logic [4:0] days;
    case (month) inside
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: days = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    days = 5'd30;
      4'd2:                                       days = is_leap ? 5'd29 : 5'd28;
      default:                                    days = 5'd0;
    endcase
    return days;
  endfunction

  jdc_jdn_to_date u_rev (
    .clk    (clk),
    .julian (request.julian_in),
    .date   (rev_date)
  );

  assign busy   = rst;
  assign done   = vld[Latency-1];
  assign result = res;

  always_comb begin
    year_ext = {1'b0, request.year_in};
    q100     = f2_p3[Div100S +: 8];
    t3x      = 10'(q100) * 10'd3;
    jsum     = 25'(f2_p1[24:2]) + 25'(f2_t2) + 25'(f2_d) - 25'(t3x[9:2]) - 25'(JdnEpoch);
    f3_next.date.year        = f2_y;
    f3_next.date.month       = f2_m;
    f3_next.date.day         = f2_d;
    f3_next.date.range_error = f2_err;
    f3_next.jdn              = f2_err ? 23'd0 : jsum[22:0];

    info_last = info[RevLatency-1];
    pad_last  = pad[FwdPad-1];
    sel_date  = (info_last.req_type == ReqJdnToDate) ? rev_date : pad_last.date;
    sel_j     = (info_last.req_type == ReqJdnToDate) ? info_last.julian : pad_last.jdn;

    yq   = m10_yp[Div100S +: 8];
    hund = 14'(yq) * 14'd100;
    leap = (m10_date.year[1:0] == 2'b00) && ((m10_date.year != hund) || (yq[1:0] == 2'b00));
    mlen = month_days(m10_date.month, leap);
    ok   = !m10_date.range_error && (m10_date.day != 5'd0) && (m10_date.day <= mlen);

    res_next.julian_out  = m10_j;
    res_next.year_out    = ok ? m10_date.year : 14'd0;
    res_next.month_out   = ok ? m10_date.month : 4'd0;
    res_next.day_out     = ok ? m10_date.day : 5'd0;
    res_next.packed_date = ok ? (27'(m10_date.year) * 27'd10000 + 27'(m10_date.month) * 27'd100
                                 + 27'(m10_date.day)) : 27'd0;
    res_next.date_valid  = ok;
    res_next.range_error = m10_date.range_error;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < Latency; i++) vld[i] <= 1'b0;
    end else begin
      vld[0] <= start && !busy;
      for (int i = 1; i < Latency; i++) vld[i] <= vld[i-1];
    end
  end

  always_ff @(posedge clk) begin
    info[0] <= {request.req_type, request.julian_in};
    for (int i = 1; i < RevLatency; i++) info[i] <= info[i-1];

    f1_y   <= request.year_in;
    f1_m   <= request.month_in;
    f1_d   <= request.day_in;
    f1_k1  <= year_ext + ((request.month_in <= 4'd2) ? 15'(JdnYearBase - 1) : 15'(JdnYearBase));
    f1_k3  <= year_ext + ((request.month_in <= 4'd2) ? 15'(JdnCentBase - 1) : 15'(JdnCentBase));
    f1_err <= (request.year_in > 14'(YearMax));

    f2_p1  <= 25'(f1_k1) * 25'(QuadYearDays);
    f2_p3  <= Div100PW'(f1_k3) * Div100PW'(Div100M);
    f2_t2  <= MonthOffset[f1_m];
    f2_y   <= f1_y;
    f2_m   <= f1_m;
    f2_d   <= f1_d;
    f2_err <= f1_err;

    pad[0] <= f3_next;
    for (int i = 1; i < FwdPad; i++) pad[i] <= pad[i-1];

    m10_date <= sel_date;
    m10_j    <= sel_j;
    m10_yp   <= Div100PW'(sel_date.year) * Div100PW'(Div100M);

    res <= res_next;
  end

endmodule

// ----- rtl/jdc_checker.sv -----
// Port-level checks for the Julian day conversion block, bound to the top level.
`include "julian_day_conversion_defines.svh"

module jdc_checker (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic              done,
  input jdc_pkg::jdc_res_t result
);
  import jdc_pkg::*;

  `JDC_ASSERT_DELAY(a_fixed_latency, clk, rst, start && !busy, Latency, done)
  `JDC_ASSERT_IMPL(a_no_orphan, clk, rst, done, $past(start && !busy, Latency))
  `JDC_ASSERT_IMPL(a_range_invalid, clk, rst, done && result.range_error, !result.date_valid)
  `JDC_ASSERT_IMPL(a_invalid_zero, clk, rst, done && !result.date_valid, (result.year_out == 14'd0) && (result.month_out == 4'd0) && (result.day_out == 5'd0) && (result.packed_date == 27'd0))

endmodule

bind julian_day_conversion jdc_checker u_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);
